[rtl/ps2_mouse_packet_tracker_assert.svh]
// Assertion macros for the PS/2 mouse packet tracker.
// Included by the checker; needs nothing else.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Checked while out of reset.
`define PMT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pmt_pkg.sv]
// Shared types and constants of the PS/2 mouse packet tracker.
// No dependencies.
`timescale 1ns / 1ps

package pmt_pkg;

  // Header byte fields
  localparam logic [7:0] HDR_SYNC_MASK = 8'h08;
  localparam logic [7:0] HDR_OVF_MASK  = 8'hC0;
  localparam logic [7:0] HDR_BTN_MASK  = 8'h07;
  localparam int unsigned HDR_XSIGN_BIT = 4;
  localparam int unsigned HDR_YSIGN_BIT = 5;

  // Configuration and cursor reset values
  localparam logic [11:0] X_LIMIT_RST = 12'd1023;
  localparam logic [11:0] Y_LIMIT_RST = 12'd767;
  localparam logic [11:0] POS_X_RST   = 12'd512;
  localparam logic [11:0] POS_Y_RST   = 12'd384;

  // Register indexes (address bit 2)
  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  // Packets buffered between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } packet_t;

endpackage

[rtl/pmt_if.sv]
// Valid/ready channels of the PS/2 mouse packet tracker.
// No dependencies.
`timescale 1ns / 1ps

interface pmt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmt_result_if;
  logic               valid;
  logic               ready;
  logic        [11:0] cursor_x;
  logic        [11:0] cursor_y;
  logic        [2:0]  button_bits;
  logic signed [8:0]  delta_x;
  logic signed [8:0]  delta_y;
  logic        [31:0] packets_seen;

  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  output delta_x, output delta_y, output packets_seen, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                  input delta_x, input delta_y, input packets_seen, output ready);
endinterface

[rtl/pmt_front.sv]
// Front end: byte framing, header sync and overflow filtering.
// Depends on pmt_pkg; pushes complete packets into pmt_queue.
`timescale 1ns / 1ps

module pmt_front
  import pmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_data_i,
  output logic       byte_ready_o,
  input  logic       queue_full_i,
  output logic       push_o,
  output packet_t    push_pkt_o
);

  typedef enum logic [1:0] {
    SLOT_HDR = 2'd0,
    SLOT_X   = 2'd1,
    SLOT_Y   = 2'd2
  } slot_e;

  slot_e      slot_q, slot_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] xmv_q, xmv_d;
  logic       take;

  // Only the closing byte of a packet needs room in the queue.
  assign byte_ready_o = !(slot_q == SLOT_Y && queue_full_i);
  assign take         = byte_valid_i && byte_ready_o;

  assign push_pkt_o = '{header: hdr_q, x_move: xmv_q, y_move: byte_data_i};

  always_comb begin
    slot_d = slot_q;
    hdr_d  = hdr_q;
    xmv_d  = xmv_q;
    push_o = 1'b0;
    if (take) begin
      case (slot_q)
        SLOT_X: begin
          xmv_d  = byte_data_i;
          slot_d = SLOT_Y;
        end
        SLOT_Y: begin
          slot_d = SLOT_HDR;
          push_o = (hdr_q & HDR_OVF_MASK) == 8'h00;
        end
        default: begin
          // resync: a header must carry the always-one bit
          if ((byte_data_i & HDR_SYNC_MASK) != 8'h00) begin
            hdr_d  = byte_data_i;
            slot_d = SLOT_X;
          end else begin
            slot_d = SLOT_HDR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_HDR;
      hdr_q  <= 8'h00;
      xmv_q  <= 8'h00;
    end else begin
      slot_q <= slot_d;
      hdr_q  <= hdr_d;
      xmv_q  <= xmv_d;
    end
  end

endmodule

[rtl/pmt_queue.sv]
// Short packet queue between front and back ends.
// Depends on pmt_pkg (packet_t, QUEUE_DEPTH).
`timescale 1ns / 1ps

module pmt_queue
  import pmt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  packet_t push_pkt_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    nonempty_o,
  output packet_t head_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  packet_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o     = cnt_q == CntW'(QUEUE_DEPTH);
  assign nonempty_o = cnt_q != '0;
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/pmt_back.sv]
// Back end: cursor update with clamping, packet count and result register.
// Depends on pmt_pkg; pops packets from pmt_queue.
`timescale 1ns / 1ps

module pmt_back
  import pmt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [11:0]        x_limit_i,
  input  logic [11:0]        y_limit_i,
  input  logic               pkt_valid_i,
  input  packet_t            pkt_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [11:0]        cursor_x_o,
  output logic [11:0]        cursor_y_o,
  output logic [2:0]         button_bits_o,
  output logic signed [8:0]  delta_x_o,
  output logic signed [8:0]  delta_y_o,
  output logic [31:0]        packets_seen_o
);

  logic                  valid_q;
  logic [11:0]           pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [COUNT_BITS-1:0] count_q;
  logic [2:0]            btn_q;
  logic signed [8:0]     dx_q, dy_q, dx, dy;
  logic signed [13:0]    sum_x, sum_y;
  logic [2:0]            btn_byte;
  logic                  load;

  function automatic logic [11:0] clamp(input logic signed [13:0] v, input logic [11:0] lim);
    logic [11:0] r;
    if (v < 0) begin
      r = 12'd0;
    end else if (v[12:0] > {1'b0, lim}) begin
      r = lim;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  assign load  = pkt_valid_i && (!valid_q || res_ready_i);
  assign pop_o = load;

  assign dx       = $signed({pkt_i.header[HDR_XSIGN_BIT], pkt_i.x_move});
  assign dy       = $signed({pkt_i.header[HDR_YSIGN_BIT], pkt_i.y_move});
  assign sum_x    = $signed({2'b00, pos_x_q}) + 14'(dx);
  assign sum_y    = $signed({2'b00, pos_y_q}) - 14'(dy);
  assign pos_x_d  = clamp(sum_x, x_limit_i);
  assign pos_y_d  = clamp(sum_y, y_limit_i);
  assign btn_byte = pkt_i.header[2:0] & HDR_BTN_MASK[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_x_q <= POS_X_RST;
      pos_y_q <= POS_Y_RST;
      count_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        count_q <= count_q + 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      btn_q <= btn_byte;
      dx_q  <= dx;
      dy_q  <= dy;
    end
  end

  assign res_valid_o    = valid_q;
  assign cursor_x_o     = pos_x_q;
  assign cursor_y_o     = pos_y_q;
  assign button_bits_o  = btn_q;
  assign delta_x_o      = dx_q;
  assign delta_y_o      = dy_q;
  assign packets_seen_o = 32'(count_q);

endmodule

[rtl/ps2_mouse_packet_tracker.sv]
// PS/2 mouse packet tracker: takes one mouse byte per cycle and delivers one cursor
// result per valid three-byte packet. A byte is accepted every cycle; only the third
// byte of a packet waits, and only when the two-entry packet queue between the framing
// front end and the cursor back end is full. Each packet is written to the queue, then its
// result to an output register that holds it until taken; the back end retires one packet
// per cycle when that register is free. Limits are written over APB at 0x0 (x) and 0x4 (y).
// Depends on pmt_pkg, pmt_if, pmt_front, pmt_queue and pmt_back.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker
  import pmt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pmt_byte_if.sink      byte_i,
  pmt_result_if.source  result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [11:0] x_limit_q, y_limit_q;
  logic        cfg_wr;
  logic        push, queue_full, pop, pkt_valid;
  packet_t     push_pkt, head_pkt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= X_LIMIT_RST;
      y_limit_q <= Y_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_X_LIMIT) begin
        x_limit_q <= pwdata[11:0];
      end else begin
        y_limit_q <= pwdata[11:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_Y_LIMIT) ? {20'd0, y_limit_q} : {20'd0, x_limit_q};

  pmt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_i.valid),
    .byte_data_i  (byte_i.rx_byte),
    .byte_ready_o (byte_i.ready),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_pkt_o   (push_pkt)
  );

  pmt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pkt_i (push_pkt),
    .full_o     (queue_full),
    .pop_i      (pop),
    .nonempty_o (pkt_valid),
    .head_o     (head_pkt)
  );

  pmt_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_limit_i      (x_limit_q),
    .y_limit_i      (y_limit_q),
    .pkt_valid_i    (pkt_valid),
    .pkt_i          (head_pkt),
    .pop_o          (pop),
    .res_valid_o    (result_o.valid),
    .res_ready_i    (result_o.ready),
    .cursor_x_o     (result_o.cursor_x),
    .cursor_y_o     (result_o.cursor_y),
    .button_bits_o  (result_o.button_bits),
    .delta_x_o      (result_o.delta_x),
    .delta_y_o      (result_o.delta_y),
    .packets_seen_o (result_o.packets_seen)
  );

endmodule

[rtl/pmt_checker.sv]
// Port-level assertions of the PS/2 mouse packet tracker, bound to the top level.
// Depends on ps2_mouse_packet_tracker_assert.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_assert.svh"

module pmt_checker #(
  parameter int unsigned COUNT_BITS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] cursor_x_i,
  input logic [11:0] cursor_y_i,
  input logic [31:0] packets_seen_i
);

  localparam int unsigned CmpW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  logic [31:0] last_seen_q;
  logic [31:0] next_seen;
  logic        out_acc;

  assign out_acc   = out_valid_i && out_ready_i;
  assign next_seen = 32'(CmpW'(last_seen_q[CmpW-1:0] + 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seen_q <= '0;
    end else if (out_acc) begin
      last_seen_q <= packets_seen_i;
    end
  end

  // each delivered packet advances the count by exactly one
  `PMT_ASSERT_RST(a_count_step, clk_i, rst_ni, out_acc |-> packets_seen_i == next_seen, "packets_seen did not advance by one")
  `PMT_ASSERT_ALWAYS(a_quiet_after_reset, clk_i, $rose(rst_ni) |-> !out_valid_i, "result valid right after reset")
  `PMT_ASSERT_RST(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result request dropped while stalled")
  `PMT_ASSERT_RST(a_payload_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(cursor_x_i) && $stable(cursor_y_i) && $stable(packets_seen_i), "result changed while stalled")

endmodule

bind ps2_mouse_packet_tracker pmt_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_pmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .cursor_x_i     (result_o.cursor_x),
  .cursor_y_i     (result_o.cursor_y),
  .packets_seen_i (result_o.packets_seen)
);

[sim/testbench.sv]
// Self-checking testbench for ps2_mouse_packet_tracker: byte stream in, cursor results out.
// A scoreboard class tracks packet framing and cursor state; results are checked in order.
// Depends on pmt_pkg, pmt_if and the tracker RTL.
`timescale 1ns / 1ps

module testbench;
  import pmt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 200;
  localparam int unsigned NUM_PHASES = 7;

  typedef enum logic [1:0] {
    SLOT_HEADER,
    SLOT_X_MOVE,
    SLOT_Y_MOVE
  } byte_slot_e;

  typedef struct {
    logic        [11:0] cursor_x;
    logic        [11:0] cursor_y;
    logic        [2:0]  button_bits;
    logic signed [8:0]  delta_x;
    logic signed [8:0]  delta_y;
    logic        [31:0] packets_seen;
  } cursor_result_t;

  class cursor_scoreboard;
    logic [11:0]     x_lim;
    logic [11:0]     y_lim;
    byte_slot_e      slot;
    logic [7:0]      header;
    logic [7:0]      x_move;
    logic [11:0]     pos_x;
    logic [11:0]     pos_y;
    logic [31:0]     good_packets;
    cursor_result_t  expected_cursor_q[$];
    int              errors;

    function new();
      x_lim = X_LIMIT_RST;
      y_lim = Y_LIMIT_RST;
      slot = SLOT_HEADER;
      header = '0;
      x_move = '0;
      pos_x = POS_X_RST;
      pos_y = POS_Y_RST;
      good_packets = '0;
      errors = 0;
    endfunction

    function void set_limit(logic idx, logic [11:0] value);
      if (idx == REG_X_LIMIT) x_lim = value;
      else y_lim = value;
    endfunction

    function int pending();
      return expected_cursor_q.size();
    endfunction

    static function logic [11:0] clamp(int v, logic [11:0] limit);
      if (v < 0) return '0;
      if (v > int'(limit)) return limit;
      return v[11:0];
    endfunction

    // Accepted byte: advance framing and, on a good third byte, the cursor.
    function void note_byte(logic [7:0] b);
      cursor_result_t r;
      int sx;
      int sy;
      if (slot == SLOT_X_MOVE) begin
        x_move = b;
        slot = SLOT_Y_MOVE;
        return;
      end
      if (slot != SLOT_Y_MOVE) begin
        // bytes without the sync bit are dropped while hunting for a header
        if ((b & HDR_SYNC_MASK) != 0) begin
          header = b;
          slot = SLOT_X_MOVE;
        end
        return;
      end
      slot = SLOT_HEADER;
      if ((header & HDR_OVF_MASK) != 0) return;
      r.delta_x = {header[HDR_XSIGN_BIT], x_move};
      r.delta_y = {header[HDR_YSIGN_BIT], b};
      sx = r.delta_x;
      sy = r.delta_y;
      // y on screen grows downward, the mouse reports it upward
      pos_x = clamp(int'(pos_x) + sx, x_lim);
      pos_y = clamp(int'(pos_y) - sy, y_lim);
      good_packets = good_packets + 1;
      r.cursor_x = pos_x;
      r.cursor_y = pos_y;
      r.button_bits = header[2:0] & HDR_BTN_MASK[2:0];
      r.packets_seen = good_packets;
      expected_cursor_q.push_back(r);
    endfunction

    function void check_result(cursor_result_t act);
      cursor_result_t exp_r;
      if (expected_cursor_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d count=%0d", $time,
                 act.cursor_x, act.cursor_y, act.packets_seen);
        errors++;
        return;
      end
      exp_r = expected_cursor_q.pop_front();
      if (act.cursor_x !== exp_r.cursor_x) begin
        $display("%0t: cursor_x expected %0d got %0d", $time, exp_r.cursor_x, act.cursor_x);
        errors++;
      end
      if (act.cursor_y !== exp_r.cursor_y) begin
        $display("%0t: cursor_y expected %0d got %0d", $time, exp_r.cursor_y, act.cursor_y);
        errors++;
      end
      if (act.button_bits !== exp_r.button_bits) begin
        $display("%0t: button_bits expected %b got %b", $time, exp_r.button_bits,
                 act.button_bits);
        errors++;
      end
      if (act.delta_x !== exp_r.delta_x) begin
        $display("%0t: delta_x expected %0d got %0d", $time, exp_r.delta_x, act.delta_x);
        errors++;
      end
      if (act.delta_y !== exp_r.delta_y) begin
        $display("%0t: delta_y expected %0d got %0d", $time, exp_r.delta_y, act.delta_y);
        errors++;
      end
      if (act.packets_seen !== exp_r.packets_seen) begin
        $display("%0t: packets_seen expected %0d got %0d", $time, exp_r.packets_seen,
                 act.packets_seen);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pmt_byte_if   byte_bus ();
  pmt_result_if result_bus ();

  ps2_mouse_packet_tracker dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cursor_scoreboard sb = new();
  bit               calm;
  int unsigned      cycle_count = 0;
  int unsigned      stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones; none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: check taken results, then choose next ready
  always @(posedge clk_i) begin
    cursor_result_t act;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      act.cursor_x = result_bus.cursor_x;
      act.cursor_y = result_bus.cursor_y;
      act.button_bits = result_bus.button_bits;
      act.delta_x = result_bus.delta_x;
      act.delta_y = result_bus.delta_y;
      act.packets_seen = result_bus.packets_seen;
      sb.check_result(act);
    end
    if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_bus.valid <= 1'b1;
    byte_bus.rx_byte <= b;
    do @(posedge clk_i); while (!byte_bus.ready);
    sb.note_byte(b);
  endtask

  function automatic logic [7:0] pick_move();
    logic [7:0] extremes[4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 7) == 0) return extremes[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_packet();
    logic [7:0] hdr;
    hdr = 8'($urandom_range(0, 255));
    hdr = hdr | HDR_SYNC_MASK;
    if ($urandom_range(0, 9) != 0) hdr = hdr & ~HDR_OVF_MASK;
    send_byte(hdr);
    send_byte(pick_move());
    send_byte(pick_move());
  endtask

  // let every outstanding request drain before touching the limits
  task automatic wait_idle();
    byte_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [11:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_limit(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [11:0] xl;
    logic [11:0] yl;
    int unsigned n;

    directed = '{
      8'h00, 8'hF7,               // no sync bit: dropped
      8'h08, 8'hFF, 8'h00,        // largest +x
      8'h38, 8'h00, 8'h00,        // most negative x and y
      8'h0F, 8'h7F, 8'h80,        // all buttons, mid deltas
      8'hC8, 8'h11, 8'h22,        // overflow: dropped
      8'h08, 8'hFF, 8'h00,
      8'h08, 8'hFF, 8'h00,        // x pinned at the limit
      8'h08, 8'h00, 8'hFF         // y pushed toward zero
    };
    rst_ni = 1'b0;
    calm = 1'b0;
    byte_bus.valid <= 1'b0;
    byte_bus.rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'hFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin xl = 12'd0;    yl = 12'd0;    end
        1: begin xl = 12'd4095; yl = 12'd4095; end
        3: begin xl = 12'd5;    yl = 12'd3;    end  // below the current position
        4: begin
          xl = 12'($urandom_range(0, 300));
          yl = 12'($urandom_range(0, 300));
        end
        5: begin xl = 12'd4095; yl = 12'd0;    end
        6: begin xl = X_LIMIT_RST; yl = Y_LIMIT_RST; end
        default: begin
          xl = 12'($urandom_range(0, 4095));
          yl = 12'($urandom_range(0, 4095));
        end
      endcase
      write_limit(REG_X_LIMIT, xl);
      write_limit(REG_Y_LIMIT, yl);
      calm = (p == 1) || ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray byte, may knock the framing off
          send_byte(8'($urandom_range(0, 255)));
          n += 1;
        end else begin
          send_packet();
          n += 3;
        end
      end
    end

    calm = 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
